// ===== sv/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

  // Byte offsets are this wide; the offset counter saturates at its top value.
  localparam int unsigned PosBits = 20;
  localparam logic [PosBits-1:0] PosMax = '1;

  localparam logic [15:0] Sat16      = 16'hFFFF;
  localparam logic [15:0] LimitReset = 16'd1024;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNul     = 8'h00;

  // Token kinds
  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_LET    = 5'd2;
  localparam logic [4:0] KIND_PLUS   = 5'd7;
  localparam logic [4:0] KIND_MINUS  = 5'd8;
  localparam logic [4:0] KIND_STAR   = 5'd9;
  localparam logic [4:0] KIND_SLASH  = 5'd10;
  localparam logic [4:0] KIND_PCT    = 5'd11;
  localparam logic [4:0] KIND_ASSIGN = 5'd12;
  localparam logic [4:0] KIND_EQ     = 5'd13;
  localparam logic [4:0] KIND_NE     = 5'd14;
  localparam logic [4:0] KIND_LT     = 5'd15;
  localparam logic [4:0] KIND_GT     = 5'd16;
  localparam logic [4:0] KIND_LE     = 5'd17;
  localparam logic [4:0] KIND_GE     = 5'd18;
  localparam logic [4:0] KIND_LPAREN = 5'd19;
  localparam logic [4:0] KIND_RPAREN = 5'd20;
  localparam logic [4:0] KIND_LBRACE = 5'd21;
  localparam logic [4:0] KIND_RBRACE = 5'd22;
  localparam logic [4:0] KIND_SEMI   = 5'd23;
  localparam logic [4:0] KIND_EOF    = 5'd24;
  localparam logic [4:0] KIND_ERROR  = 5'd25;

  // Keywords, right-aligned; keyword k reports as KIND_LET + k
  localparam int unsigned NumKw = 5;
  localparam logic [39:0] KwText [NumKw] = '{"let", "print", "if", "else", "while"};
  localparam logic [2:0]  KwLen  [NumKw] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_HELD,
    MODE_COMMENT,
    MODE_STOPPED,
    MODE_FAILED
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [7:0]         held;
    logic [PosBits-1:0] cstart;
    logic [15:0]        clen;
    logic [15:0]        line;
    logic [PosBits-1:0] bpos;
    logic [15:0]        temit;
    logic [NumKw-1:0]   kwm;
  } scan_st_t;

  localparam scan_st_t ScanReset = '{
    mode:   MODE_IDLE,
    held:   8'h00,
    cstart: '0,
    clen:   16'd0,
    line:   16'd1,
    bpos:   '0,
    temit:  16'd0,
    kwm:    '1
  };

  typedef struct packed {
    logic [4:0]         kind;
    logic [15:0]        line;
    logic [PosBits-1:0] start;
    logic [15:0]        length;
    logic [7:0]         code;
  } tok_t;

  // Up to three tokens from one byte
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } grp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PCT;
      "=":     k = KIND_ASSIGN;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] double_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "=":     k = KIND_EQ;
      "!":     k = KIND_NE;
      "<":     k = KIND_LE;
      default: k = KIND_GE;
    endcase
    return k;
  endfunction

  // Character i of keyword k; only used with i below the keyword length
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    logic [5:0] sh;
    sh = {3'(KwLen[k] - 3'd1 - i), 3'b000};
    return KwText[k][sh +: 8];
  endfunction

  // Drop keywords that cannot match once c sits at position idx
  function automatic logic [NumKw-1:0] match_kw(input logic [NumKw-1:0] mask,
                                                input logic [15:0] idx,
                                                input logic [7:0] c);
    logic [NumKw-1:0] m;
    m = mask;
    for (int k = 0; k < NumKw; k++) begin
      if ((idx >= 16'(KwLen[k])) || (kw_char(k, idx[2:0]) != c)) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic active(input scan_st_t s, input logic [15:0] limit);
    return (({1'b0, s.temit} + 17'd1) < {1'b0, limit});
  endfunction

  function automatic void put(inout grp_t g, input logic [15:0] line,
                              input logic [4:0] kind, input logic [PosBits-1:0] start,
                              input logic [15:0] len, input logic [7:0] code);
    if (g.cnt != 2'd3) begin
      g.tok[g.cnt] = '{kind: kind, line: line, start: start, length: len, code: code};
      g.cnt = g.cnt + 2'd1;
    end
  endfunction

  function automatic void put_token(inout grp_t g, inout scan_st_t s,
                                    input logic [15:0] limit, input logic [4:0] kind,
                                    input logic [PosBits-1:0] start,
                                    input logic [15:0] len, input logic [7:0] code);
    put(g, s.line, kind, start, len, code);
    if (s.temit != Sat16) begin
      s.temit = s.temit + 16'd1;
    end
    if (!active(s, limit)) begin
      s.mode = MODE_STOPPED;
    end
  endfunction

  function automatic void finish_word(inout grp_t g, inout scan_st_t s,
                                      input logic [15:0] limit);
    logic [4:0] kind;
    kind = KIND_IDENT;
    if (s.mode == MODE_NUMBER) begin
      kind = KIND_NUMBER;
    end else begin
      for (int k = 0; k < NumKw; k++) begin
        if (s.kwm[k] && (s.clen == 16'(KwLen[k]))) begin
          kind = KIND_LET + 5'(k);
        end
      end
    end
    s.mode = MODE_IDLE;
    put_token(g, s, limit, kind, s.cstart, s.clen, ChNul);
  endfunction

  function automatic void release_held(inout grp_t g, inout scan_st_t s,
                                       input logic [15:0] limit);
    logic [7:0] c;
    c = s.held;
    if (c == "!") begin
      s.mode = MODE_FAILED;
      put(g, s.line, KIND_ERROR, s.cstart, 16'd1, c);
    end else begin
      s.mode = MODE_IDLE;
      put_token(g, s, limit, single_kind(c), s.cstart, 16'd1, c);
    end
  endfunction

  function automatic void start_byte(inout grp_t g, inout scan_st_t s,
                                     input logic [15:0] limit, input logic [7:0] c,
                                     input logic [PosBits-1:0] pos);
    logic [4:0] kind;
    kind = single_kind(c);
    if (c == ChNewline) begin
      if (s.line != Sat16) begin
        s.line = s.line + 16'd1;
      end
    end else if (is_space(c)) begin
      // skipped
    end else if (is_digit(c)) begin
      s.mode   = MODE_NUMBER;
      s.cstart = pos;
      s.clen   = 16'd1;
    end else if (is_alpha(c)) begin
      s.mode   = MODE_IDENT;
      s.cstart = pos;
      s.kwm    = match_kw('1, 16'd0, c);
      s.clen   = 16'd1;
    end else if ((c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "/")) begin
      s.mode   = MODE_HELD;
      s.held   = c;
      s.cstart = pos;
    end else if (kind == KIND_ERROR) begin
      s.mode = MODE_FAILED;
      put(g, s.line, KIND_ERROR, pos, 16'd1, c);
    end else begin
      put_token(g, s, limit, kind, pos, 16'd1, c);
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/stt_txt_if.sv =====
`default_nettype none

// Source text channel: one byte per word
interface stt_txt_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== sv/stt_tok_if.sv =====
`default_nettype none

// Token channel: one token per word
interface stt_tok_if;
  logic                       valid;
  logic                       ready;
  logic [4:0]                 token_kind;
  logic [15:0]                token_line;
  logic [stt_pkg::PosBits-1:0] token_start;
  logic [15:0]                token_length;
  logic [7:0]                 char_code;
  logic                       last_of_run;

  modport source (output valid, output token_kind, output token_line, output token_start,
                  output token_length, output char_code, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_start,
                  input token_length, input char_code, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/stt_cfg_if.sv =====
`default_nettype none

// Token limit write channel
interface stt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_limit;

  modport source (output valid, output token_limit, input ready);
  modport sink   (input valid, input token_limit, output ready);
endinterface

`default_nettype wire

// ===== sv/stt_step.sv =====
`default_nettype none

// Scanner step: one byte against the current scan state, giving the next
// state and the group of tokens the byte produces.
module stt_step (
  input  var stt_pkg::scan_st_t st_i,
  input  var logic [15:0]       limit_i,
  input  var logic [7:0]        char_i,
  input  var logic              last_i,
  output stt_pkg::scan_st_t     st_o,
  output stt_pkg::grp_t         grp_o
);

  stt_pkg::scan_st_t            s;
  stt_pkg::grp_t                g;
  logic [stt_pkg::PosBits-1:0]  pos;
  logic                         do_start;

  always_comb begin
    s        = st_i;
    g        = '0;
    do_start = 1'b0;

    // byte offset, saturating
    pos = s.bpos;
    if (s.bpos != stt_pkg::PosMax) begin
      s.bpos = s.bpos + {{(stt_pkg::PosBits-1){1'b0}}, 1'b1};
    end

    if ((s.mode == stt_pkg::MODE_IDLE) && !stt_pkg::active(s, limit_i)) begin
      s.mode = stt_pkg::MODE_STOPPED;
    end

    case (s.mode)
      stt_pkg::MODE_IDLE: begin
        do_start = 1'b1;
      end
      stt_pkg::MODE_COMMENT: begin
        if (char_i == stt_pkg::ChNewline) begin
          if (s.line != stt_pkg::Sat16) begin
            s.line = s.line + 16'd1;
          end
          s.mode = stt_pkg::MODE_IDLE;
        end
      end
      stt_pkg::MODE_NUMBER, stt_pkg::MODE_IDENT: begin
        if (stt_pkg::is_digit(char_i) ||
            ((s.mode == stt_pkg::MODE_IDENT) && stt_pkg::is_alpha(char_i))) begin
          if (s.mode == stt_pkg::MODE_IDENT) begin
            s.kwm = stt_pkg::match_kw(s.kwm, s.clen, char_i);
          end
          if (s.clen != stt_pkg::Sat16) begin
            s.clen = s.clen + 16'd1;
          end
        end else begin
          stt_pkg::finish_word(g, s, limit_i);
          do_start = (s.mode == stt_pkg::MODE_IDLE);
        end
      end
      stt_pkg::MODE_HELD: begin
        if ((s.held == "/") && (char_i == "/")) begin
          s.mode = stt_pkg::MODE_COMMENT;
        end else if ((char_i == "=") && (s.held != "/")) begin
          s.mode = stt_pkg::MODE_IDLE;
          stt_pkg::put_token(g, s, limit_i, stt_pkg::double_kind(s.held), s.cstart,
                             16'd2, s.held);
        end else begin
          stt_pkg::release_held(g, s, limit_i);
          do_start = (s.mode == stt_pkg::MODE_IDLE);
        end
      end
      default: begin
      end
    endcase

    if (do_start) begin
      stt_pkg::start_byte(g, s, limit_i, char_i, pos);
    end

    // end of text: flush the pending token, then EOF unless the scanner has failed, then clear
    if (last_i) begin
      if ((s.mode == stt_pkg::MODE_NUMBER) || (s.mode == stt_pkg::MODE_IDENT)) begin
        stt_pkg::finish_word(g, s, limit_i);
      end else if (s.mode == stt_pkg::MODE_HELD) begin
        stt_pkg::release_held(g, s, limit_i);
      end
      if (s.mode != stt_pkg::MODE_FAILED) begin
        stt_pkg::put(g, s.line, stt_pkg::KIND_EOF, s.bpos, 16'd0, stt_pkg::ChNul);
      end
      s = stt_pkg::ScanReset;
    end

    st_o  = s;
    grp_o = g;
  end

endmodule

`default_nettype wire

// ===== sv/source_text_tokenizer_top.sv =====
`default_nettype none

// A byte is registered at the input, then the scan step registers its tokens into
// the token group. Throughput: one byte per cycle while each byte gives at most one
// token and the token port is ready; a byte with more holds the byte pipeline until
// all its tokens are taken, as the token port moves one word per cycle.
// Reset clears the scan state (line 1, offset 0) and sets the token limit to 1024.
module source_text_tokenizer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stt_cfg_if.sink    cfg_i,
  stt_txt_if.sink    txt_i,
  stt_tok_if.source  tok_o
);

  logic [15:0]        limit_q;
  logic               in_valid_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  stt_pkg::scan_st_t  state_q;
  stt_pkg::scan_st_t  state_d;
  stt_pkg::grp_t      grp_d;
  stt_pkg::tok_t [2:0] tok_q;
  logic [1:0]         cnt_q;
  logic [1:0]         idx_q;
  logic               out_valid;
  logic               out_fire;
  logic               last_take;
  logic               grp_free;
  logic               step_go;
  logic               in_fire;

  // Token limit register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= stt_pkg::LimitReset;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.token_limit;
    end
  end

  // Handshake bookkeeping
  assign out_valid = (idx_q != cnt_q);
  assign out_fire  = out_valid && tok_o.ready;
  assign last_take = out_fire && ((idx_q + 2'd1) == cnt_q);
  assign grp_free  = !out_valid || last_take;
  assign step_go   = in_valid_q && grp_free;
  assign txt_i.ready = !in_valid_q || step_go;
  assign in_fire   = txt_i.valid && txt_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= txt_i.char_byte;
      in_last_q <= txt_i.end_of_text;
    end
  end

  stt_step u_step (
    .st_i    (state_q),
    .limit_i (limit_q),
    .char_i  (in_byte_q),
    .last_i  (in_last_q),
    .st_o    (state_d),
    .grp_o   (grp_d)
  );

  // Scan state and token group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stt_pkg::ScanReset;
      cnt_q   <= 2'd0;
      idx_q   <= 2'd0;
    end else if (step_go) begin
      state_q <= state_d;
      cnt_q   <= grp_d.cnt;
      idx_q   <= 2'd0;
    end else if (out_fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      tok_q <= grp_d.tok;
    end
  end

  // Token output, one word per cycle from the group while the sink is ready
  assign tok_o.valid        = out_valid;
  assign tok_o.token_kind   = tok_q[idx_q].kind;
  assign tok_o.token_line   = tok_q[idx_q].line;
  assign tok_o.token_start  = tok_q[idx_q].start;
  assign tok_o.token_length = tok_q[idx_q].length;
  assign tok_o.char_code    = tok_q[idx_q].code;
  assign tok_o.last_of_run  = ((idx_q + 2'd1) == cnt_q);

`ifndef SYNTHESIS
  // read index never passes the group size
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_q)
    else $error("token group index past count");

  // line count never drops to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line != 16'd0)
    else $error("line number is zero");

  // the last byte of a text leaves a clean scanner
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && in_last_q |=> (state_q.mode == stt_pkg::MODE_IDLE) &&
                             (state_q.bpos == '0) && (state_q.temit == 16'd0))
    else $error("scan state not cleared at end of text");

  // after an error nothing more comes out
  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && (state_q.mode == stt_pkg::MODE_FAILED) |=> cnt_q == 2'd0)
    else $error("token produced after error");

  // a byte waiting on a busy group is kept
  a_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !grp_free |=> in_valid_q && $stable(in_byte_q))
    else $error("pending byte lost");
`endif

endmodule

`default_nettype wire
